// ===== sv/rsba_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotated scaled blit address package
// Shared widths, register codes, beat types and helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package rsba_pkg;

    localparam int PANEL_COLS_DEF = 800;
    localparam int PANEL_ROWS_DEF = 480;

    localparam int DIM_W     = 13;
    localparam int STEP_W    = 12;
    localparam int PROD_W    = 25;
    localparam int QUO_W     = 12;
    localparam int POS_W     = 15;
    localparam int SRC_W     = 26;
    localparam int DST_W     = 21;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_ROTATION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_COLS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ROWS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS = 3'd6;

    typedef struct packed {
        logic [STEP_W-1:0] step_col;
        logic [STEP_W-1:0] step_row;
    } t_in;

    typedef struct packed {
        logic             in_view;
        logic [SRC_W-1:0] source_offset;
        logic [DST_W-1:0] dest_offset;
    } t_out;

    // One divider lane: partial remainder and quotient bits found so far.
    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } t_lane;

    // Destination side results riding along with the divider.
    typedef struct packed {
        logic              empty;
        logic              clamp_x;
        logic              clamp_y;
        logic              in_view;
        logic [STEP_W-1:0] px;
        logic [STEP_W-1:0] py;
    } t_pass;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/rsba_front.sv =====
// ----------------------------------------------------------------------------
// Rotated scaled blit address front stage
// Forms the scale products, rotates and clips the destination point.
// ----------------------------------------------------------------------------
`default_nettype none
module rsba_front #(
    parameter int PANEL_COLS = rsba_pkg::PANEL_COLS_DEF,
    parameter int PANEL_ROWS = rsba_pkg::PANEL_ROWS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  rsba_pkg::t_in                i_item,
    input  wire  [1:0]                   i_rotation,
    input  wire  [rsba_pkg::DIM_W-1:0]   i_dest_left,
    input  wire  [rsba_pkg::DIM_W-1:0]   i_dest_top,
    input  wire  [rsba_pkg::DIM_W-1:0]   i_dcols,
    input  wire  [rsba_pkg::DIM_W-1:0]   i_drows,
    input  wire  [rsba_pkg::DIM_W-1:0]   i_scols,
    input  wire  [rsba_pkg::DIM_W-1:0]   i_srows,
    output logic                         o_valid,
    output rsba_pkg::t_lane              o_lane_x,
    output rsba_pkg::t_lane              o_lane_y,
    output rsba_pkg::t_pass              o_pass
);
    import rsba_pkg::*;

    localparam logic signed [POS_W-1:0] COLS_S = POS_W'(PANEL_COLS);
    localparam logic signed [POS_W-1:0] ROWS_S = POS_W'(PANEL_ROWS);
    localparam logic signed [POS_W-1:0] ONE_S  = POS_W'(1);

    logic signed [POS_W-1:0] x, y, px, py;
    logic                    view;
    t_lane                   n_lane_x, n_lane_y;
    t_pass                   n_pass;
    logic                    r_valid;
    t_lane                   r_lane_x, r_lane_y;
    t_pass                   r_pass;

    always_comb begin
        x = $signed({{(POS_W-DIM_W){i_dest_left[DIM_W-1]}}, i_dest_left})
            + $signed({{(POS_W-STEP_W){1'b0}}, i_item.step_col});
        y = $signed({{(POS_W-DIM_W){i_dest_top[DIM_W-1]}}, i_dest_top})
            + $signed({{(POS_W-STEP_W){1'b0}}, i_item.step_row});
        case (i_rotation)
            2'd1: begin
                px = y;
                py = ROWS_S - ONE_S - x;
            end
            2'd2: begin
                px = COLS_S - ONE_S - x;
                py = ROWS_S - ONE_S - y;
            end
            2'd3: begin
                px = COLS_S - ONE_S - y;
                py = x;
            end
            default: begin
                px = x;
                py = y;
            end
        endcase
        view = (px >= 0) && (px < COLS_S) && (py >= 0) && (py < ROWS_S);

        n_lane_x.rem = PROD_W'(i_item.step_col) * PROD_W'(i_scols);
        n_lane_x.quo = '0;
        n_lane_y.rem = PROD_W'(i_item.step_row) * PROD_W'(i_srows);
        n_lane_y.quo = '0;

        n_pass.empty   = (i_dcols == '0) || (i_drows == '0) || (i_scols == '0)
                         || (i_srows == '0);
        // A step at or beyond the rectangle edge maps past the source edge.
        n_pass.clamp_x = {1'b0, i_item.step_col} >= i_dcols;
        n_pass.clamp_y = {1'b0, i_item.step_row} >= i_drows;
        n_pass.in_view = view;
        n_pass.px      = px[STEP_W-1:0];
        n_pass.py      = py[STEP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_lane_x <= n_lane_x;
        r_lane_y <= n_lane_y;
        r_pass   <= n_pass;
    end

    assign o_valid  = r_valid;
    assign o_lane_x = r_lane_x;
    assign o_lane_y = r_lane_y;
    assign o_pass   = r_pass;

endmodule
`default_nettype wire

// ===== sv/rsba_cell.sv =====
// ----------------------------------------------------------------------------
// Rotated scaled blit address divider cell
// Resolves one quotient bit for both axes and hands the beat on.
// ----------------------------------------------------------------------------
`default_nettype none
module rsba_cell #(
    parameter int BIT = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  rsba_pkg::t_lane              i_lane_x,
    input  rsba_pkg::t_lane              i_lane_y,
    input  rsba_pkg::t_pass              i_pass,
    input  wire  [rsba_pkg::DIM_W-1:0]   i_div_x,
    input  wire  [rsba_pkg::DIM_W-1:0]   i_div_y,
    output logic                         o_valid,
    output rsba_pkg::t_lane              o_lane_x,
    output rsba_pkg::t_lane              o_lane_y,
    output rsba_pkg::t_pass              o_pass
);
    import rsba_pkg::*;

    logic [PROD_W-1:0] trial_x, trial_y;
    t_lane             n_lane_x, n_lane_y;
    logic              r_valid;
    t_lane             r_lane_x, r_lane_y;
    t_pass             r_pass;

    always_comb begin
        trial_x  = PROD_W'(i_div_x) << BIT;
        trial_y  = PROD_W'(i_div_y) << BIT;
        n_lane_x = i_lane_x;
        n_lane_y = i_lane_y;
        if (i_lane_x.rem >= trial_x) begin
            n_lane_x.rem      = i_lane_x.rem - trial_x;
            n_lane_x.quo[BIT] = 1'b1;
        end
        if (i_lane_y.rem >= trial_y) begin
            n_lane_y.rem      = i_lane_y.rem - trial_y;
            n_lane_y.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_lane_x <= n_lane_x;
        r_lane_y <= n_lane_y;
        r_pass   <= i_pass;
    end

    assign o_valid  = r_valid;
    assign o_lane_x = r_lane_x;
    assign o_lane_y = r_lane_y;
    assign o_pass   = r_pass;

endmodule
`default_nettype wire

// ===== sv/rsba_back.sv =====
// ----------------------------------------------------------------------------
// Rotated scaled blit address back end
// Turns source and panel coordinates into byte offsets over two stages.
// ----------------------------------------------------------------------------
`default_nettype none
module rsba_back #(
    parameter int PANEL_COLS = rsba_pkg::PANEL_COLS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire  [rsba_pkg::QUO_W-1:0]   i_quo_x,
    input  wire  [rsba_pkg::QUO_W-1:0]   i_quo_y,
    input  rsba_pkg::t_pass              i_pass,
    input  wire  [rsba_pkg::DIM_W-1:0]   i_scols,
    input  wire  [rsba_pkg::DIM_W-1:0]   i_srows,
    output logic                         o_strobe,
    output rsba_pkg::t_out               o_result
);
    import rsba_pkg::*;

    localparam logic [DIM_W-1:0] COLS_C = DIM_W'(PANEL_COLS);

    logic [DIM_W-1:0]  scols_m1, srows_m1;
    logic [QUO_W-1:0]  sx, sy;
    logic [SRC_W-1:0]  sum_s, sum_d;
    t_out              n_result;

    logic              r_valid1, r_strobe;
    logic [PROD_W-1:0] r_mul_s, r_mul_d;
    logic [QUO_W-1:0]  r_sx;
    logic [STEP_W-1:0] r_px;
    logic              r_view, r_empty;
    t_out              r_result;

    always_comb begin
        scols_m1 = i_scols - DIM_W'(1);
        srows_m1 = i_srows - DIM_W'(1);
        sx = i_pass.clamp_x ? scols_m1[QUO_W-1:0] : i_quo_x;
        sy = i_pass.clamp_y ? srows_m1[QUO_W-1:0] : i_quo_y;

        sum_s = SRC_W'(r_mul_s) + SRC_W'(r_sx);
        sum_d = SRC_W'(r_mul_d) + SRC_W'(r_px);
        n_result.in_view       = r_view && !r_empty;
        n_result.source_offset = r_empty ? '0 : (sum_s << 1) + sum_s;
        n_result.dest_offset   = n_result.in_view ? DST_W'((sum_d << 1) + sum_d) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_strobe <= r_valid1;
        end
        r_mul_s  <= PROD_W'(sy) * PROD_W'(i_scols);
        r_mul_d  <= PROD_W'(i_pass.py) * PROD_W'(COLS_C);
        r_sx     <= sx;
        r_px     <= i_pass.px;
        r_view   <= i_pass.in_view;
        r_empty  <= i_pass.empty;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== sv/rotated_scaled_blit_address.sv =====
// ----------------------------------------------------------------------------
// Rotated scaled blit address unit
// Pipeline: a front stage, one divider cell per source coordinate bit, twelve
// in all, and two offset stages lead from start to the result strobe.
// Throughput: one beat per cycle; busy stays low and the receiver cannot stall.
// Reset is synchronous and active low: it clears the pipeline valids and sets
// rotation and origin to zero and all four extents to one.
// ----------------------------------------------------------------------------
`default_nettype none
module rotated_scaled_blit_address #(
    parameter int PANEL_COLS = rsba_pkg::PANEL_COLS_DEF,
    parameter int PANEL_ROWS = rsba_pkg::PANEL_ROWS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  rsba_pkg::t_in                  i_item,
    output logic                           o_strobe,
    output rsba_pkg::t_out                 o_result,
    input  wire                            i_cfg_we,
    input  wire  [rsba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [rsba_pkg::DIM_W-1:0]     i_cfg_data
);
    import rsba_pkg::*;

    logic [1:0]       r_rotation;
    logic [DIM_W-1:0] r_dest_left, r_dest_top;
    logic [DIM_W-1:0] r_dest_cols, r_dest_rows, r_source_cols, r_source_rows;
    logic [DIM_W-1:0] dcols, drows, scols, srows;

    logic  valid [0:QUO_W];
    t_lane lane_x [0:QUO_W];
    t_lane lane_y [0:QUO_W];
    t_pass pass [0:QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation    <= 2'd0;
            r_dest_left   <= '0;
            r_dest_top    <= '0;
            r_dest_cols   <= DIM_W'(1);
            r_dest_rows   <= DIM_W'(1);
            r_source_cols <= DIM_W'(1);
            r_source_rows <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROTATION:    r_rotation    <= i_cfg_data[1:0];
                REG_DEST_LEFT:   r_dest_left   <= i_cfg_data;
                REG_DEST_TOP:    r_dest_top    <= i_cfg_data;
                REG_DEST_COLS:   r_dest_cols   <= i_cfg_data;
                REG_DEST_ROWS:   r_dest_rows   <= i_cfg_data;
                REG_SOURCE_COLS: r_source_cols <= i_cfg_data;
                REG_SOURCE_ROWS: r_source_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign dcols = sat_dim(r_dest_cols);
    assign drows = sat_dim(r_dest_rows);
    assign scols = sat_dim(r_source_cols);
    assign srows = sat_dim(r_source_rows);
    assign busy  = 1'b0;

    rsba_front #(
        .PANEL_COLS (PANEL_COLS),
        .PANEL_ROWS (PANEL_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_item      (i_item),
        .i_rotation  (r_rotation),
        .i_dest_left (r_dest_left),
        .i_dest_top  (r_dest_top),
        .i_dcols     (dcols),
        .i_drows     (drows),
        .i_scols     (scols),
        .i_srows     (srows),
        .o_valid     (valid[0]),
        .o_lane_x    (lane_x[0]),
        .o_lane_y    (lane_y[0]),
        .o_pass      (pass[0])
    );

    // Quotient bits are resolved most significant first along the chain.
    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        rsba_cell #(
            .BIT (QUO_W - 1 - k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (valid[k]),
            .i_lane_x (lane_x[k]),
            .i_lane_y (lane_y[k]),
            .i_pass   (pass[k]),
            .i_div_x  (dcols),
            .i_div_y  (drows),
            .o_valid  (valid[k+1]),
            .o_lane_x (lane_x[k+1]),
            .o_lane_y (lane_y[k+1]),
            .o_pass   (pass[k+1])
        );
    end

    rsba_back #(
        .PANEL_COLS (PANEL_COLS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (valid[QUO_W]),
        .i_quo_x  (lane_x[QUO_W].quo),
        .i_quo_y  (lane_y[QUO_W].quo),
        .i_pass   (pass[QUO_W]),
        .i_scols  (scols),
        .i_srows  (srows),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.in_view |-> o_result.dest_offset == '0)
        else $error("clipped beat carries a destination offset");

    a_strobe_follows_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        valid[QUO_W] |=> ##1 o_strobe)
        else $error("beat leaving the divider chain was lost");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(valid[QUO_W], 2))
        else $error("result strobe without a beat from the divider chain");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_rotated_scaled_blit_address.sv =====
// ----------------------------------------------------------------------------
// Rotated scaled blit address testbench
// Streams destination pixels through the address unit under several register
// settings and checks every result beat against a scoreboard prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

class blit_scoreboard;
    rsba_pkg::t_out pending[$];
    int unsigned    errors;

    logic [1:0]  rotation;
    logic [12:0] dest_left, dest_top, dest_cols, dest_rows, source_cols, source_rows;

    function void reset_regs();
        rotation = 0; dest_left = 0; dest_top = 0;
        dest_cols = 1; dest_rows = 1; source_cols = 1; source_rows = 1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [12:0] data);
        case (idx)
            rsba_pkg::REG_ROTATION:    rotation = data[1:0];
            rsba_pkg::REG_DEST_LEFT:   dest_left = data;
            rsba_pkg::REG_DEST_TOP:    dest_top = data;
            rsba_pkg::REG_DEST_COLS:   dest_cols = data;
            rsba_pkg::REG_DEST_ROWS:   dest_rows = data;
            rsba_pkg::REG_SOURCE_COLS: source_cols = data;
            rsba_pkg::REG_SOURCE_ROWS: source_rows = data;
            default: ;
        endcase
    endfunction

    function int unsigned clamp_dim(logic [12:0] v);
        return (v > 13'd4096) ? 4096 : v;
    endfunction

    function int unsigned scaled_coord(int unsigned step, int unsigned src, int unsigned dst);
        int unsigned s;
        s = (step * src) / dst;
        return (s >= src) ? src - 1 : s;
    endfunction

    function void note_pixel(rsba_pkg::t_in px_in);
        int unsigned dc, dr, sc, sr, sx, sy;
        int x, y, px, py;
        rsba_pkg::t_out r;
        dc = clamp_dim(dest_cols); dr = clamp_dim(dest_rows);
        sc = clamp_dim(source_cols); sr = clamp_dim(source_rows);
        r = '0;
        if (dc != 0 && dr != 0 && sc != 0 && sr != 0) begin
            sx = scaled_coord(px_in.step_col, sc, dc);
            sy = scaled_coord(px_in.step_row, sr, dr);
            r.source_offset = 26'((sy * sc + sx) * 3);
            x = $signed(dest_left) + int'(px_in.step_col);
            y = $signed(dest_top) + int'(px_in.step_row);
            case (rotation)
                2'd1: begin px = y; py = 479 - x; end
                2'd2: begin px = 799 - x; py = 479 - y; end
                2'd3: begin px = 799 - y; py = x; end
                default: begin px = x; py = y; end
            endcase
            r.in_view = px >= 0 && px < 800 && py >= 0 && py < 480;
            if (r.in_view) r.dest_offset = 21'((py * 800 + px) * 3);
        end
        pending.push_back(r);
    endfunction

    function void check_result(rsba_pkg::t_out got);
        rsba_pkg::t_out want;
        if (pending.size() == 0) begin
            $error("unexpected result beat");
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.in_view !== want.in_view) begin
            $error("in_view: expected %0d, actual %0d", want.in_view, got.in_view);
            errors++;
        end
        if (got.source_offset !== want.source_offset) begin
            $error("source_offset: expected %0d, actual %0d",
                   want.source_offset, got.source_offset);
            errors++;
        end
        if (got.dest_offset !== want.dest_offset) begin
            $error("dest_offset: expected %0d, actual %0d",
                   want.dest_offset, got.dest_offset);
            errors++;
        end
    endfunction
endclass

module tb_rotated_scaled_blit_address;
    localparam int LATENCY = 15;
    localparam int CYCLE_LIMIT = 200000;

    logic           i_clk = 0;
    logic           i_rst_n = 0;
    logic           start = 0;
    logic           busy;
    rsba_pkg::t_in  i_item = '0;
    logic           o_strobe;
    rsba_pkg::t_out o_result;
    logic           i_cfg_we = 0;
    logic [2:0]     i_cfg_idx = 0;
    logic [12:0]    i_cfg_data = 0;

    blit_scoreboard board;
    int unsigned    cycles;
    int unsigned    send_idle_pct;

    rotated_scaled_blit_address dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** rotated_scaled_blit_address: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.check_result(o_result);
    end

    // The write enable stays high across a run of writes; the caller drops it.
    task automatic write_reg(logic [2:0] idx, logic [12:0] data);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Waits until the pipeline has drained, then a further margin set by LATENCY.
    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [11:0] col, logic [11:0] row);
        rsba_pkg::t_in beat;
        beat.step_col = col; beat.step_row = row;
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1; i_item <= beat;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_pixel(beat);
    endtask

    task automatic end_burst();
        start <= 0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [1:0] rot, logic [12:0] l, logic [12:0] t,
                             logic [12:0] dc, logic [12:0] dr,
                             logic [12:0] sc, logic [12:0] sr);
        drain();
        write_reg(rsba_pkg::REG_ROTATION, {11'd0, rot});
        write_reg(rsba_pkg::REG_DEST_LEFT, l);
        write_reg(rsba_pkg::REG_DEST_TOP, t);
        write_reg(rsba_pkg::REG_DEST_COLS, dc);
        write_reg(rsba_pkg::REG_DEST_ROWS, dr);
        write_reg(rsba_pkg::REG_SOURCE_COLS, sc);
        write_reg(rsba_pkg::REG_SOURCE_ROWS, sr);
        i_cfg_we <= 0;
    endtask

    // Mostly sensible extents, sometimes zero, the maximum, or above it.
    function automatic logic [12:0] pick_dim();
        case ($urandom_range(9))
            0: return 13'd0;
            1: return 13'd4096;
            2: return 13'($urandom_range(8191, 4097));
            3: return 13'($urandom_range(4095, 1));
            default: return 13'($urandom_range(900, 1));
        endcase
    endfunction

    initial begin
        board = new();
        board.reset_regs();
        cycles = 0;
        send_idle_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset setting, then extremes of every register and field.
        send_pixel(0, 0);
        send_pixel(12'hFFF, 12'hFFF);
        end_burst();
        for (int r = 0; r < 4; r++) begin
            write_all(2'(r), 0, 0, 800, 480, 4096, 4096);
            send_pixel(0, 0);
            send_pixel(799, 479);
            send_pixel(800, 480);
            end_burst();
        end
        write_all(1, 13'h1000, 13'h0FFF, 4096, 4096, 1, 4096);
        send_pixel(12'hFFF, 0);
        send_pixel(0, 12'hFFF);
        end_burst();
        write_all(2, 13'h0FFF, 13'h1000, 8191, 0, 7, 3);
        send_pixel(5, 5);
        end_burst();
        write_all(3, 13'h1FFF, 13'h1FFF, 1, 1, 4096, 8191);
        send_pixel(0, 0);
        send_pixel(12'hABC, 12'h543);
        end_burst();

        for (int ph = 0; ph < 30; ph++) begin
            logic [12:0] dc, dr;
            send_idle_pct = (ph < 10) ? 19 : (ph < 20) ? 68 : 0;
            dc = pick_dim(); dr = pick_dim();
            write_all(2'($urandom_range(3)), 13'($urandom_range(8191)),
                      13'($urandom_range(8191)), dc, dr, pick_dim(), pick_dim());
            for (int n = 0; n < 62; n++) begin
                if ($urandom_range(9) == 0)
                    send_pixel(12'($urandom), 12'($urandom));
                else
                    send_pixel(12'((dc == 0) ? 0
                                   : $urandom_range((dc > 4096 ? 4096 : dc) - 1)),
                               12'((dr == 0) ? 0
                                   : $urandom_range((dr > 4096 ? 4096 : dr) - 1)));
                if (n == 30 && ph == 5) begin
                    end_burst();
                    while (board.pending.size() != 0) @(posedge i_clk);
                end
            end
            end_burst();
        end

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("** rotated_scaled_blit_address: PASSED **");
        else
            $display("** rotated_scaled_blit_address: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
